### hdl/rckt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rckt_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 16;
    localparam int COUNT_BITS = 8;

    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // fixed port field widths
    localparam int KEY_IN_W   = 16;
    localparam int SLOT_W     = 4;
    localparam int CNT_OUT_W  = 8;
    localparam int STATUS_W   = 3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(ENTRIES - 1);

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT   = 3'd0,
        ST_NEW   = 3'd1,
        ST_FULL  = 3'd2,
        ST_STILL = 3'd3,
        ST_FREED = 3'd4,
        ST_IDLE  = 3'd5,
        ST_OVF   = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_REL,
        S_DECIDE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture request
        logic rd;      // read entry at pointer
        logic step;    // advance pointer
        logic cmp;     // evaluate read entry
        logic commit;  // update table, load result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hit_now;
        logic last;
    } t_sts;

endpackage
`default_nettype wire

### hdl/rckt_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module rckt_dp (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire  rckt_pkg::t_cmd               i_cmd,
    output rckt_pkg::t_sts                     o_sts,
    input  wire                                i_action,
    input  wire  [rckt_pkg::KEY_IN_W-1:0]      i_key_number,
    input  wire  [rckt_pkg::SLOT_W-1:0]        i_slot_index,
    output logic [rckt_pkg::STATUS_W-1:0]      o_status,
    output logic [rckt_pkg::SLOT_W-1:0]        o_slot_out,
    output logic [rckt_pkg::CNT_OUT_W-1:0]     o_count_after
);

    localparam int IDX_W = rckt_pkg::IDX_W;
    localparam int KB    = rckt_pkg::KEY_BITS;
    localparam int CB    = rckt_pkg::COUNT_BITS;

    logic [KB-1:0] mem_key [rckt_pkg::ENTRIES];
    logic [CB-1:0] r_cnt   [rckt_pkg::ENTRIES];

    logic                       r_action;
    logic [KB-1:0]              r_key;
    logic [rckt_pkg::SLOT_W-1:0] r_slot;
    logic                       r_oob;
    logic [IDX_W-1:0]           r_ptr;

    logic                       r_rd_vld;
    logic [KB-1:0]              r_rd_key;
    logic [CB-1:0]              r_rd_cnt;
    logic [IDX_W-1:0]           r_rd_idx;

    logic                       r_hit;
    logic [IDX_W-1:0]           r_hit_idx;
    logic [CB-1:0]              r_hit_cnt;
    logic                       r_have_free;
    logic [IDX_W-1:0]           r_free_idx;

    rckt_pkg::t_status           r_status;
    logic [rckt_pkg::SLOT_W-1:0] r_slot_out;
    logic [rckt_pkg::CNT_OUT_W-1:0] r_count_after;

    rckt_pkg::t_status           n_status;
    logic [rckt_pkg::SLOT_W-1:0] n_slot_out;
    logic [CB-1:0]               n_cnt;
    logic                        cnt_we;
    logic [IDX_W-1:0]            cnt_wa;
    logic                        key_we;
    logic                        in_use;
    logic                        key_eq;

    assign in_use = (r_rd_cnt != '0);
    assign key_eq = (r_rd_key == r_key);

    assign o_sts.hit_now = r_rd_vld && in_use && key_eq;
    assign o_sts.last    = (r_ptr == rckt_pkg::LAST_IDX);

    always_comb begin
        n_status   = rckt_pkg::ST_FULL;
        n_slot_out = '0;
        n_cnt      = '0;
        cnt_we     = 1'b0;
        cnt_wa     = r_ptr;
        key_we     = 1'b0;
        if (!r_action) begin
            if (r_hit) begin
                n_slot_out = rckt_pkg::SLOT_W'(r_hit_idx);
                cnt_wa     = r_hit_idx;
                if (r_hit_cnt == rckt_pkg::COUNT_MAX) begin
                    n_status = rckt_pkg::ST_OVF;
                    n_cnt    = r_hit_cnt;
                end else begin
                    n_status = rckt_pkg::ST_HIT;
                    n_cnt    = r_hit_cnt + CB'(1);
                    cnt_we   = 1'b1;
                end
            end else if (r_have_free) begin
                n_status   = rckt_pkg::ST_NEW;
                n_slot_out = rckt_pkg::SLOT_W'(r_free_idx);
                n_cnt      = CB'(1);
                cnt_wa     = r_free_idx;
                cnt_we     = 1'b1;
                key_we     = 1'b1;
            end
        end else begin
            n_slot_out = r_slot;
            if (r_oob || r_rd_cnt == '0) begin
                n_status = rckt_pkg::ST_IDLE;
            end else begin
                n_cnt    = r_rd_cnt - CB'(1);
                cnt_we   = 1'b1;
                n_status = (n_cnt == '0) ? rckt_pkg::ST_FREED : rckt_pkg::ST_STILL;
            end
        end
    end

    // request capture and scan pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_key    <= KB'(i_key_number);
            r_slot   <= i_slot_index;
            r_oob    <= (int'(i_slot_index) >= rckt_pkg::ENTRIES);
            r_ptr    <= i_action ? IDX_W'(i_slot_index) : '0;
        end else if (i_cmd.step) begin
            r_ptr    <= IDX_W'(r_ptr + IDX_W'(1));
        end
    end

    // key store, one read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && key_we) begin
            mem_key[r_free_idx] <= r_key;
        end
        if (i_cmd.rd) begin
            r_rd_key <= mem_key[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_cnt <= r_cnt[r_ptr];
            r_rd_idx <= r_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_have_free <= 1'b0;
            for (int i = 0; i < rckt_pkg::ENTRIES; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_rd_vld    <= 1'b0;
                r_hit       <= 1'b0;
                r_have_free <= 1'b0;
            end else begin
                if (i_cmd.rd) begin
                    r_rd_vld <= 1'b1;
                end
                if (i_cmd.cmp && r_rd_vld) begin
                    if (!r_hit && in_use && key_eq) begin
                        r_hit <= 1'b1;
                    end
                    // lowest free slot seen so far
                    if (!r_have_free && !in_use) begin
                        r_have_free <= 1'b1;
                    end
                end
            end
            if (i_cmd.commit && cnt_we) begin
                r_cnt[cnt_wa] <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp && r_rd_vld) begin
            if (!r_hit && in_use && key_eq) begin
                r_hit_idx <= r_rd_idx;
                r_hit_cnt <= r_rd_cnt;
            end
            if (!r_have_free && !in_use) begin
                r_free_idx <= r_rd_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status      <= n_status;
            r_slot_out    <= n_slot_out;
            r_count_after <= rckt_pkg::CNT_OUT_W'(n_cnt);
        end
    end

    assign o_status      = r_status;
    assign o_slot_out    = r_slot_out;
    assign o_count_after = r_count_after;

endmodule
`default_nettype wire

### hdl/rckt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module rckt_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  wire             i_out_stall,
    input  wire             i_action,
    input  wire rckt_pkg::t_sts i_sts,
    output rckt_pkg::t_cmd  o_cmd
);

    rckt_pkg::t_state r_state;
    rckt_pkg::t_state n_state;
    logic             r_out_valid;
    logic             accept;
    logic             out_free;

    assign accept   = i_in_valid && (r_state == rckt_pkg::S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rckt_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = i_action ? rckt_pkg::S_REL : rckt_pkg::S_SCAN;
                end
            end
            rckt_pkg::S_SCAN: begin
                if (i_sts.hit_now) begin
                    n_state = rckt_pkg::S_DECIDE;
                end else if (i_sts.last) begin
                    n_state = rckt_pkg::S_DRAIN;
                end
            end
            rckt_pkg::S_DRAIN:  n_state = rckt_pkg::S_DECIDE;
            rckt_pkg::S_REL:    n_state = rckt_pkg::S_DECIDE;
            rckt_pkg::S_DECIDE: begin
                if (out_free) begin
                    n_state = rckt_pkg::S_IDLE;
                end
            end
            default: n_state = rckt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            rckt_pkg::S_IDLE:   o_cmd.load = accept;
            rckt_pkg::S_SCAN: begin
                o_cmd.rd   = 1'b1;
                o_cmd.step = 1'b1;
                o_cmd.cmp  = 1'b1;
            end
            rckt_pkg::S_DRAIN:  o_cmd.cmp = 1'b1;
            rckt_pkg::S_REL:    o_cmd.rd  = 1'b1;
            rckt_pkg::S_DECIDE: o_cmd.commit = out_free;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rckt_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != rckt_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

### hdl/refcounted_key_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Reference-counted key table. An acquire request (action 0) scans the table one entry per
// cycle for an in-use entry holding the key; a hit bumps its count, a miss claims the
// lowest free entry with count one (status "new, needs load"), or reports full. A release
// request (action 1) lowers the count of the given slot and frees it at zero. Idle
// releases and count overflow are flagged and change nothing. A scan commits once a hit
// is seen; a miss scans to the last entry and compares it in a drain step before the
// commit. A release reads its slot, then commits. The next request can be taken in the
// cycle after the commit. The scan rate is set by the single read port of the key memory.
// The result sits in an output register; a new request is taken while it waits, and the
// block holds off its commit until the register is free. Reset clears all counts at once.
module refcounted_key_table_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire                                i_action,
    input  wire  [rckt_pkg::KEY_IN_W-1:0]      i_key_number,
    input  wire  [rckt_pkg::SLOT_W-1:0]        i_slot_index,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic [rckt_pkg::STATUS_W-1:0]      o_status,
    output logic [rckt_pkg::SLOT_W-1:0]        o_slot_out,
    output logic [rckt_pkg::CNT_OUT_W-1:0]     o_count_after
);

    rckt_pkg::t_cmd cmd;
    rckt_pkg::t_sts sts;

    rckt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_action    (i_action),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rckt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_action      (i_action),
        .i_key_number  (i_key_number),
        .i_slot_index  (i_slot_index),
        .o_status      (o_status),
        .o_slot_out    (o_slot_out),
        .o_count_after (o_count_after)
    );

endmodule
`default_nettype wire
